// File: hdl/xcrc_pkg.sv
// Shared types and constants for the XMODEM-CRC receiver.
// No dependencies; imported by every module in hdl/.
package xcrc_pkg;

  localparam int unsigned PAYLOAD_BYTES = 128;

  // Receiver phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HUNT = 3'd1;
  localparam logic [2:0] PH_BLK  = 3'd2;
  localparam logic [2:0] PH_CMP  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_CRCH = 3'd5;
  localparam logic [2:0] PH_CRCL = 3'd6;

  // Result kinds
  localparam logic [2:0] K_DATA  = 3'd0;
  localparam logic [2:0] K_ACK   = 3'd1;
  localparam logic [2:0] K_NAK   = 3'd2;
  localparam logic [2:0] K_DONE  = 3'd3;
  localparam logic [2:0] K_ABORT = 3'd4;
  localparam logic [2:0] K_C     = 3'd5;

  // Link bytes
  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_C   = 8'h43;

  localparam logic [7:0]  RETRY_RESET = 8'd5;
  localparam logic [7:0]  FAIL_MAX    = 8'hff;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [7:0]  LAST_INDEX  = 8'(PAYLOAD_BYTES);

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
  } out_item_t;

endpackage

// File: hdl/xmodem_crc_receiver.sv
// Top level of the XMODEM-CRC receiver: input register, protocol state
// machine with CRC update, result register. Depends on xcrc_pkg,
// xcrc_crc_byte and xcrc_out_reg.
//
// Usage:
//   in_data carries one beat per received byte (mode 0) or a start command
//   (mode 1). A start clears the transfer and yields a 'C' beat. Payload bytes
//   come out as kind DATA beats; after the two CRC bytes an ACK or NAK beat
//   follows, or ABORT once failures in a row reach cfg retry_limit
//   (0 behaves as 1). EOT while hunting gives a DONE beat. Other bytes give
//   no beat.
//   An accepted beat waits in the input register until the result register is
//   free, is then processed, and its result is registered onto out_data.
//   Throughput: one beat per cycle while out_stall does not hold a result; the
//   state machine and the byte-wide CRC update are combinational.
//   Reset: synchronous, clears the state machine to idle, block 1,
//   retry_limit 5, and empties both registers.
//   When out_stall holds a result, in_stall rises once the input register
//   also holds a beat, whether or not it makes a result; up to two beats stay.
//   cfg_wr_en/cfg_wr_data write retry_limit; write only while idle.
module xmodem_crc_receiver (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  xcrc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output xcrc_pkg::out_item_t out_data
);
  import xcrc_pkg::*;

  logic       retry_zero;
  logic [7:0] retry_r;

  logic       in_valid_r;
  logic       in_valid_nxt;
  in_item_t   in_item_r;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  block_r, block_nxt;
  logic [7:0]  fail_r, fail_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  index_r, index_nxt;

  logic [15:0] crc_fold;
  logic [7:0]  limit;
  logic [7:0]  index_inc;
  logic        res_valid;
  out_item_t   res;
  logic        out_free;
  logic        advance;

  xcrc_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (in_item_r.rx_byte),
    .crc_out (crc_fold)
  );

  xcrc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .load_data (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_r <= RETRY_RESET;
    end else if (cfg_wr_en) begin
      retry_r <= cfg_wr_data;
    end
  end

  assign retry_zero = (retry_r == 8'd0);  // zero acts as one
  assign limit      = retry_zero ? 8'd1 : retry_r;

  // input register
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && !in_stall) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_data;
    end
  end

  // protocol state machine
  assign index_inc = index_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    block_nxt = block_r;
    fail_nxt  = fail_r;
    crc_nxt   = crc_r;
    index_nxt = index_r;
    res_valid = 1'b0;
    res       = '{kind: K_DATA, value: 8'h00};
    if (in_item_r.mode) begin
      phase_nxt = PH_HUNT;
      block_nxt = 8'd1;
      fail_nxt  = 8'd0;
      crc_nxt   = 16'h0000;
      index_nxt = 8'd0;
      res_valid = 1'b1;
      res       = '{kind: K_C, value: B_C};
    end else begin
      case (phase_r)
        PH_HUNT: begin
          if (in_item_r.rx_byte == B_EOT) begin
            phase_nxt = PH_IDLE;
            res_valid = 1'b1;
            res       = '{kind: K_DONE, value: 8'h00};
          end else if (in_item_r.rx_byte == B_SOH) begin
            phase_nxt = PH_BLK;
          end
        end
        PH_BLK: begin
          phase_nxt = (in_item_r.rx_byte == block_r) ? PH_CMP : PH_HUNT;
        end
        PH_CMP: begin
          if (in_item_r.rx_byte == ~block_r) begin
            crc_nxt   = 16'h0000;
            index_nxt = 8'd0;
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_DATA: begin
          crc_nxt   = crc_fold;
          index_nxt = index_inc;
          if (index_inc >= LAST_INDEX) begin
            phase_nxt = PH_CRCH;
          end
          res_valid = 1'b1;
          res       = '{kind: K_DATA, value: in_item_r.rx_byte};
        end
        PH_CRCH: begin
          crc_nxt   = crc_fold;
          phase_nxt = PH_CRCL;
        end
        PH_CRCL: begin
          crc_nxt   = crc_fold;
          res_valid = 1'b1;
          if (crc_fold == 16'h0000) begin
            block_nxt = block_r + 8'd1;
            fail_nxt  = 8'd0;
            phase_nxt = PH_HUNT;
            res       = '{kind: K_ACK, value: B_ACK};
          end else begin
            if (fail_r != FAIL_MAX) begin
              fail_nxt = fail_r + 8'd1;
            end
            if (fail_nxt >= limit) begin
              phase_nxt = PH_IDLE;
              res       = '{kind: K_ABORT, value: 8'h00};
            end else begin
              phase_nxt = PH_HUNT;
              res       = '{kind: K_NAK, value: B_NAK};
            end
          end
        end
        default: begin
          // idle and the unused code: bytes are dropped
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      block_r <= 8'd1;
      fail_r  <= 8'd0;
      crc_r   <= 16'h0000;
      index_r <= 8'd0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      block_r <= block_nxt;
      fail_r  <= fail_nxt;
      crc_r   <= crc_nxt;
      index_r <= index_nxt;
    end
  end

endmodule

// File: hdl/xcrc_crc_byte.sv
// CRC-16/XMODEM byte update (poly 0x1021, MSB first), combinational.
// Depends on xcrc_pkg.
module xcrc_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);
  import xcrc_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// File: hdl/xcrc_out_reg.sv
// Result register for the receiver's output channel (valid/stall).
// Depends on xcrc_pkg.
module xcrc_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  xcrc_pkg::out_item_t load_data,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output xcrc_pkg::out_item_t out_data
);
  import xcrc_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  // slot frees up in the same cycle the held beat leaves
  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: test/xmodem_crc_receiver_tb.sv
// Self-checking testbench for xmodem_crc_receiver: a directed table, then random
// XMODEM blocks under random stalls, each checked against a receiver model.
// Depends on xcrc_pkg and the xmodem_crc_receiver RTL.
module xmodem_crc_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xcrc_pkg::*;

  localparam int WATCHDOG          = 2000;
  localparam int LONG_HOLD         = 300;
  localparam int ITEMS_PER_SETTING = 225;
  localparam int SETTINGS_N        = 5;

  // Protocol state of the receiver as the testbench tracks it
  typedef struct packed {
    logic [2:0]  phase;
    logic [7:0]  want_blk;
    logic [7:0]  fails;
    logic [15:0] crc;
    logic [7:0]  count;
    logic [7:0]  limit;
  } link_t;

  typedef struct packed {
    link_t     st;
    logic      hit;
    out_item_t res;
  } link_step_t;

  // Where the expected beat of a table row comes from
  typedef enum logic [1:0] {PREDICTED, SILENT, LISTED} source_t;

  typedef enum logic [1:0] {BLK_GOOD, BLK_BADCRC, BLK_CUT} blk_t;

  typedef struct packed {
    in_item_t  beat;
    source_t   src;
    out_item_t fixed;
  } plan_row_t;

  localparam out_item_t NONE_OUT = '0;
  localparam int PLAN_LEN = 25;

  plan_row_t plan [PLAN_LEN] = '{
    // idle after reset: bytes are dropped
    '{{1'b0, 8'h00}, SILENT,    NONE_OUT},
    '{{1'b0, 8'hff}, SILENT,    NONE_OUT},
    '{{1'b0, B_SOH}, SILENT,    NONE_OUT},
    '{{1'b1, 8'hff}, LISTED,    {K_C, B_C}},
    '{{1'b0, 8'h00}, PREDICTED, NONE_OUT},
    '{{1'b0, 8'hff}, PREDICTED, NONE_OUT},
    '{{1'b0, B_EOT}, LISTED,    {K_DONE, 8'h00}},
    '{{1'b0, B_EOT}, SILENT,    NONE_OUT},
    '{{1'b1, 8'h00}, LISTED,    {K_C, B_C}},
    '{{1'b0, B_SOH}, PREDICTED, NONE_OUT},
    '{{1'b0, 8'h02}, PREDICTED, NONE_OUT},  // wrong block number
    '{{1'b0, B_SOH}, PREDICTED, NONE_OUT},
    '{{1'b0, 8'h01}, PREDICTED, NONE_OUT},
    '{{1'b0, 8'h00}, PREDICTED, NONE_OUT},  // wrong complement
    '{{1'b0, B_SOH}, PREDICTED, NONE_OUT},
    '{{1'b0, 8'h01}, PREDICTED, NONE_OUT},
    '{{1'b0, B_SOH}, PREDICTED, NONE_OUT},  // bad complement is consumed, not a SOH
    '{{1'b0, B_SOH}, PREDICTED, NONE_OUT},
    '{{1'b0, 8'h01}, PREDICTED, NONE_OUT},
    '{{1'b0, 8'hfe}, PREDICTED, NONE_OUT},
    '{{1'b0, 8'h00}, LISTED,    {K_DATA, 8'h00}},
    '{{1'b0, 8'hff}, LISTED,    {K_DATA, 8'hff}},
    '{{1'b0, B_EOT}, LISTED,    {K_DATA, B_EOT}},
    '{{1'b1, 8'h5a}, LISTED,    {K_C, B_C}},  // restart mid-block
    '{{1'b0, B_EOT}, LISTED,    {K_DONE, 8'h00}}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;

  out_item_t  pending_out [$];
  link_t      rx_model;
  link_t      tx_view;
  source_t    row_src = PREDICTED;
  out_item_t  row_fixed = '0;
  logic       in_took = 1'b0;
  logic       hold_req = 1'b0;
  logic       tight = 1'b0;
  int         errors = 0;
  int         live_beats = 0;
  int         idle_cycles = 0;
  logic [7:0] limits [SETTINGS_N] = '{8'd1, 8'd0, FAIL_MAX, 8'd2, 8'd0};

  xmodem_crc_receiver i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] crc_xmodem(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic link_t link_reset();
    link_t s;
    s.phase    = PH_IDLE;
    s.want_blk = 8'd1;
    s.fails    = 8'd0;
    s.crc      = 16'h0000;
    s.count    = 8'd0;
    s.limit    = RETRY_RESET;
    return s;
  endfunction

  // Next receiver state and the beat (if any) that one input causes
  function automatic link_step_t link_step(input link_t s, input in_item_t b);
    link_step_t o;
    logic [7:0] lim;
    logic [7:0] inv;
    o.st  = s;
    o.hit = 1'b0;
    o.res = '0;
    lim = (s.limit == 8'd0) ? 8'd1 : s.limit;
    inv = ~s.want_blk;
    if (b.mode) begin
      o.st.phase    = PH_HUNT;
      o.st.want_blk = 8'd1;
      o.st.fails    = 8'd0;
      o.st.crc      = 16'h0000;
      o.st.count    = 8'd0;
      o.hit         = 1'b1;
      o.res         = {K_C, B_C};
    end else begin
      case (s.phase)
        PH_HUNT: begin
          if (b.rx_byte == B_EOT) begin
            o.st.phase = PH_IDLE;
            o.hit      = 1'b1;
            o.res      = {K_DONE, 8'h00};
          end else if (b.rx_byte == B_SOH) begin
            o.st.phase = PH_BLK;
          end
        end
        PH_BLK: o.st.phase = (b.rx_byte == s.want_blk) ? PH_CMP : PH_HUNT;
        PH_CMP: begin
          if (b.rx_byte == inv) begin
            o.st.crc   = 16'h0000;
            o.st.count = 8'd0;
            o.st.phase = PH_DATA;
          end else begin
            o.st.phase = PH_HUNT;
          end
        end
        PH_DATA: begin
          o.st.crc   = crc_xmodem(s.crc, b.rx_byte);
          o.st.count = s.count + 8'd1;
          if (o.st.count >= LAST_INDEX) o.st.phase = PH_CRCH;
          o.hit = 1'b1;
          o.res = {K_DATA, b.rx_byte};
        end
        PH_CRCH: begin
          o.st.crc   = crc_xmodem(s.crc, b.rx_byte);
          o.st.phase = PH_CRCL;
        end
        PH_CRCL: begin
          o.st.crc = crc_xmodem(s.crc, b.rx_byte);
          o.hit    = 1'b1;
          if (o.st.crc == 16'h0000) begin
            o.st.want_blk = s.want_blk + 8'd1;
            o.st.fails    = 8'd0;
            o.st.phase    = PH_HUNT;
            o.res         = {K_ACK, B_ACK};
          end else begin
            if (s.fails != FAIL_MAX) o.st.fails = s.fails + 8'd1;
            if (o.st.fails >= lim) begin
              o.st.phase = PH_IDLE;
              o.res      = {K_ABORT, 8'h00};
            end else begin
              o.st.phase = PH_HUNT;
              o.res      = {K_NAK, B_NAK};
            end
          end
        end
        default: o.st.phase = PH_IDLE;
      endcase
    end
    return o;
  endfunction

  // Accepted beats on both channels, expectation queue and watchdog
  always @(posedge clk) begin : mon
    link_step_t nx;
    out_item_t  want;
    if (!rst_n) begin
      rx_model = link_reset();
      pending_out.delete();
      in_took = 1'b0;
      idle_cycles = 0;
    end else begin
      if (cfg_wr_en) rx_model.limit = cfg_wr_data;
      in_took = in_valid && !in_stall;
      if (in_took) begin
        nx = link_step(rx_model, in_data);
        rx_model = nx.st;
        case (row_src)
          PREDICTED: if (nx.hit) pending_out.push_back(nx.res);
          LISTED:    pending_out.push_back(row_fixed);
          default:   ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_out.size() == 0) begin
          $display("%0t: unexpected beat kind %0d value %02h", $time,
                   out_data.kind, out_data.value);
          errors++;
        end else begin
          want = pending_out.pop_front();
          if (out_data.kind !== want.kind) begin
            $display("%0t: kind mismatch, expected %0d, got %0d", $time,
                     want.kind, out_data.kind);
            errors++;
          end
          if (out_data.value !== want.value) begin
            $display("%0t: value mismatch, expected %02h, got %02h", $time,
                     want.value, out_data.value);
            errors++;
          end
        end
      end
      if (in_took || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Result side: random stalls, clean stretches, and one long hold-off
  initial begin : drain
    int r;
    int len;
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        len = LONG_HOLD;
      end else if (r < 40) begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 4);
      end else if (r < 70) begin
        out_stall <= 1'b1;
        len = $urandom_range(1, 3);
      end else if (r < 80) begin
        out_stall <= 1'b0;
        len = $urandom_range(30, 120);
      end else if (r < 85) begin
        out_stall <= 1'b1;
        len = $urandom_range(20, 60);
      end else begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 10);
      end
      repeat (len) @(negedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tight || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(input in_item_t b, input source_t src, input out_item_t fixed);
    link_step_t nx;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    nx = link_step(tx_view, b);
    if (nx.hit || nx.st != tx_view) live_beats++;
    tx_view = nx.st;
    row_src = src;
    row_fixed = fixed;
    in_valid <= 1'b1;
    in_data <= b;
    do @(negedge clk); while (!in_took);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_beat({1'b0, b}, PREDICTED, NONE_OUT);
  endtask

  task automatic send_start();
    send_beat({1'b1, 8'($urandom)}, PREDICTED, NONE_OUT);
  endtask

  // Junk that never starts a header or ends the transfer
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 6)) begin
      b = 8'($urandom);
      if (b == B_SOH || b == B_EOT) b = b ^ 8'h80;
      send_byte(b);
    end
  endtask

  task automatic send_bad_header();
    logic [7:0] blk;
    blk = tx_view.want_blk;
    send_byte(B_SOH);
    if ($urandom_range(0, 1)) begin
      send_byte(blk ^ 8'($urandom_range(1, 255)));
    end else begin
      send_byte(blk);
      send_byte(~blk ^ 8'($urandom_range(1, 255)));
    end
  endtask

  task automatic send_block(input blk_t how);
    logic [15:0] crc;
    logic [7:0]  blk;
    logic [7:0]  pay;
    int cut;
    blk = tx_view.want_blk;
    crc = 16'h0000;
    cut = $urandom_range(0, PAYLOAD_BYTES);
    send_byte(B_SOH);
    send_byte(blk);
    send_byte(~blk);
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (how == BLK_CUT && i == cut) begin
        send_start();
        return;
      end
      pay = 8'($urandom);
      crc = crc_xmodem(crc, pay);
      send_byte(pay);
    end
    if (how == BLK_BADCRC) crc ^= 16'h0001 << $urandom_range(0, 15);
    send_byte(crc[15:8]);
    if (how == BLK_CUT) begin
      send_start();
      return;
    end
    send_byte(crc[7:0]);
  endtask

  task automatic run_frame();
    int r;
    tight = ($urandom_range(0, 3) == 0);
    if (tx_view.phase == PH_IDLE) begin
      if ($urandom_range(0, 4) == 0) send_noise();
      send_start();
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 45)      send_block(BLK_GOOD);
    else if (r < 68) send_block(BLK_BADCRC);
    else if (r < 76) send_block(BLK_CUT);
    else if (r < 86) send_bad_header();
    else if (r < 94) send_noise();
    else if (r < 97) send_start();
    else             send_byte(B_EOT);
  endtask

  // Stop sending, let every result out and the pipeline run dry
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_retry(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tx_view.limit = v;
  endtask

  initial begin : stim
    int goal;
    tx_view = link_reset();
    limits[SETTINGS_N-1] = 8'($urandom_range(3, 254));
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_beat(plan[i].beat, plan[i].src, plan[i].fixed);

    foreach (limits[p]) begin
      settle();
      write_retry(limits[p]);
      if (limits[p] == FAIL_MAX) hold_req = 1'b1;
      goal = live_beats + ITEMS_PER_SETTING;
      while (live_beats < goal) run_frame();
    end
    settle();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/xcrc_pkg.sv
hdl/xcrc_crc_byte.sv
hdl/xcrc_out_reg.sv
hdl/xmodem_crc_receiver.sv
test/xmodem_crc_receiver_tb.sv
